// ----- sv/qclh_pkg.sv -----
// Shared types and constants for the quad channel level histogram.
// No dependencies; every other file of the block imports this package.
package qclh_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int FIELD_BITS     = 24;
  localparam int BYTE_BITS      = 8;
  localparam int CODE_BITS      = 2;
  localparam int NUM_CH         = 4;
  localparam int NUM_CODES      = 4;
  localparam int CH_BITS        = 2;

  localparam logic [CH_BITS-1:0]    LAST_CH      = CH_BITS'(NUM_CH - 1);
  localparam logic [FIELD_BITS-1:0] WINDOW_RESET = FIELD_BITS'(8388608);

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef field_t [NUM_CODES-1:0] code_row_t;

  typedef struct packed {
    logic                     load;
    field_t                   total;
    code_row_t [NUM_CH-1:0]   counts;
  } snap_t;

endpackage

// ----- sv/qclh_if.sv -----
// Handshake channels of the quad channel level histogram: sample input,
// report output and window length configuration. Depends on qclh_pkg.
interface qclh_in_if import qclh_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] sample_byte;

  modport source(output valid, output sample_byte, input ready);
  modport sink(input valid, input sample_byte, output ready);
endinterface

interface qclh_out_if import qclh_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [CH_BITS-1:0] channel_index;
  field_t             count_code_zero;
  field_t             count_code_one;
  field_t             count_code_two;
  field_t             count_code_three;
  field_t             window_total;
  logic               last_channel;

  modport source(output valid, output channel_index, output count_code_zero,
                 output count_code_one, output count_code_two, output count_code_three,
                 output window_total, output last_channel, input ready);
  modport sink(input valid, input channel_index, input count_code_zero,
               input count_code_one, input count_code_two, input count_code_three,
               input window_total, input last_channel, output ready);
endinterface

interface qclh_cfg_if import qclh_pkg::*;
();
  logic   valid;
  logic   ready;
  field_t window_length;

  modport source(output valid, output window_length, input ready);
  modport sink(input valid, input window_length, output ready);
endinterface

// ----- sv/qclh_in_reg.sv -----
// Input register for sample beats of the level histogram.
// Depends on qclh_pkg and qclh_in_if.
module qclh_in_reg import qclh_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  qclh_in_if.sink              in_ch,
  input  logic                 advance,
  output logic                 byte_vld,
  output logic [BYTE_BITS-1:0] sample_byte
);

  logic                 vld_r, vld_nxt;
  logic [BYTE_BITS-1:0] byte_r;
  logic                 take;

  assign in_ch.ready = !vld_r || advance;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= in_ch.sample_byte;
    end
  end

  assign byte_vld    = vld_r;
  assign sample_byte = byte_r;

endmodule

// ----- sv/qclh_counter.sv -----
// Per-channel code counters, window byte counter and window close detection.
// Depends on qclh_pkg.
module qclh_counter import qclh_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_vld,
  input  logic [BYTE_BITS-1:0] sample_byte,
  input  field_t               window_length,
  input  logic                 buf_free,
  output logic                 advance,
  output snap_t                snap
);

  localparam int CMP_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

  typedef logic [COUNT_BITS-1:0] cnt_t;

  cnt_t                 level_r   [NUM_CH][NUM_CODES];
  cnt_t                 level_nxt [NUM_CH][NUM_CODES];
  cnt_t                 level_inc [NUM_CH][NUM_CODES];
  cnt_t                 wcount_r, wcount_nxt, wcount_inc;
  logic [CODE_BITS-1:0] codes [NUM_CH];
  logic [CMP_BITS-1:0]  inc_ext, len_ext;
  logic                 close;

  function automatic field_t to_field(cnt_t v);
    logic [CMP_BITS-1:0] e;
    e = CMP_BITS'(v);
    return e[FIELD_BITS-1:0];
  endfunction

  always_comb begin
    wcount_inc = wcount_r + cnt_t'(1);
    inc_ext    = CMP_BITS'(wcount_inc);
    len_ext    = CMP_BITS'(window_length);
    close      = (inc_ext >= len_ext) || (wcount_inc == '1);
    advance    = byte_vld && (!close || buf_free);

    for (int ch = 0; ch < NUM_CH; ch++) begin
      codes[ch] = sample_byte[BYTE_BITS-1-CODE_BITS*ch -: CODE_BITS];
    end

    snap.load  = byte_vld && close && buf_free;
    snap.total = to_field(wcount_inc);
    wcount_nxt = wcount_r;
    if (advance) begin
      wcount_nxt = close ? '0 : wcount_inc;
    end

    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int cd = 0; cd < NUM_CODES; cd++) begin
        level_inc[ch][cd]   = level_r[ch][cd] + cnt_t'(codes[ch] == CODE_BITS'(cd));
        snap.counts[ch][cd] = to_field(level_inc[ch][cd]);
        level_nxt[ch][cd]   = level_r[ch][cd];
        if (advance) begin
          level_nxt[ch][cd] = close ? '0 : level_inc[ch][cd];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcount_r <= '0;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int cd = 0; cd < NUM_CODES; cd++) begin
          level_r[ch][cd] <= '0;
        end
      end
    end else begin
      wcount_r <= wcount_nxt;
      level_r  <= level_nxt;
    end
  end

endmodule

// ----- sv/qclh_report.sv -----
// Report buffer: holds one closed window and sends it as four channel beats.
// Depends on qclh_pkg and qclh_out_if.
module qclh_report import qclh_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  snap_t      snap,
  output logic       buf_free,
  qclh_out_if.source out_ch
);

  logic                   busy_r, busy_nxt;
  logic [CH_BITS-1:0]     idx_r, idx_nxt;
  field_t                 total_r;
  code_row_t [NUM_CH-1:0] counts_r;
  code_row_t              row;
  logic                   fire;

  assign fire     = busy_r && out_ch.ready;
  assign buf_free = !busy_r || (out_ch.ready && idx_r == LAST_CH);

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (snap.load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (fire) begin
      if (idx_r == LAST_CH) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + CH_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (snap.load) begin
      total_r  <= snap.total;
      counts_r <= snap.counts;
    end
  end

  always_comb begin
    row                     = counts_r[idx_r];
    out_ch.valid            = busy_r;
    out_ch.channel_index    = idx_r;
    out_ch.count_code_zero  = row[0];
    out_ch.count_code_one   = row[1];
    out_ch.count_code_two   = row[2];
    out_ch.count_code_three = row[3];
    out_ch.window_total     = total_r;
    out_ch.last_channel     = (idx_r == LAST_CH);
  end

endmodule

// ----- sv/quad_channel_level_histogram.sv -----
// Quad channel level histogram: each sample beat carries four 2-bit codes,
// channel 0 in bits 7:6 down to channel 3 in bits 1:0. The block counts each
// code per channel and the bytes of the current window. When the byte count
// reaches window_length (0 acts as 1; the counter's all-ones value also
// closes), it sends four report beats, channel 0 first, the last one flagged
// by last_channel, and clears all counts. The closing byte is counted.
// Throughput: one sample beat per cycle, set by the single counter stage,
// while the report buffer has room. A closed window occupies the report
// buffer for four output beats; a further window that closes before the
// fourth beat leaves holds the input until then, so windows shorter than
// four bytes are paced by the four report beats of each window. The first
// report beat is valid once the closing sample beat has passed the input
// register and been loaded into the report buffer, once that buffer is free.
// Receiver stall: report beats hold; sampling continues until the next
// window close needs the buffer, then in_ch.ready drops.
// cfg_ch is always ready; write only while idle. Reset (rst_n, synchronous)
// clears all counts and sets window_length to 8388608.
// Depends on qclh_pkg, qclh_if, qclh_in_reg, qclh_counter and qclh_report.
module quad_channel_level_histogram import qclh_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
  input  logic       clk,
  input  logic       rst_n,
  qclh_in_if.sink    in_ch,
  qclh_out_if.source out_ch,
  qclh_cfg_if.sink   cfg_ch
);

  field_t               window_length_r;
  logic                 advance;
  logic                 byte_vld;
  logic [BYTE_BITS-1:0] sample_byte;
  logic                 buf_free;
  snap_t                snap;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      window_length_r <= cfg_ch.window_length;
    end
  end

  qclh_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .advance     (advance),
    .byte_vld    (byte_vld),
    .sample_byte (sample_byte)
  );

  qclh_counter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_counter (
    .clk           (clk),
    .rst_n         (rst_n),
    .byte_vld      (byte_vld),
    .sample_byte   (sample_byte),
    .window_length (window_length_r),
    .buf_free      (buf_free),
    .advance       (advance),
    .snap          (snap)
  );

  qclh_report u_report (
    .clk      (clk),
    .rst_n    (rst_n),
    .snap     (snap),
    .buf_free (buf_free),
    .out_ch   (out_ch)
  );

endmodule

// ----- sv/qclh_checker.sv -----
// Port-level checks on the report channel of the level histogram, and the
// bind that attaches them to quad_channel_level_histogram. Depends on qclh_pkg.
module qclh_checker import qclh_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CH_BITS-1:0] channel_index,
  input field_t             count_code_zero,
  input field_t             count_code_one,
  input field_t             count_code_two,
  input field_t             count_code_three,
  input field_t             window_total,
  input logic               last_channel
);

  logic [FIELD_BITS+1:0] code_sum;
  logic                  mid_beat;

  assign code_sum = (FIELD_BITS+2)'(count_code_zero) + (FIELD_BITS+2)'(count_code_one)
                  + (FIELD_BITS+2)'(count_code_two) + (FIELD_BITS+2)'(count_code_three);
  assign mid_beat = out_valid && out_ready && (channel_index != LAST_CH);

  a_sum_matches_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> code_sum == (FIELD_BITS+2)'(window_total))
    else $error("code counts do not add up to window total");

  a_last_on_final_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> last_channel == (channel_index == LAST_CH))
    else $error("last_channel does not match final channel");

  a_channel_order: assert property (@(posedge clk) disable iff (!rst_n)
    mid_beat |=> out_valid && channel_index == $past(channel_index) + CH_BITS'(1))
    else $error("report beats out of channel order");

  a_total_steady: assert property (@(posedge clk) disable iff (!rst_n)
    mid_beat |=> window_total == $past(window_total))
    else $error("window total changed within a report");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(channel_index)
      && $stable(count_code_zero) && $stable(window_total))
    else $error("stalled report beat changed");

endmodule

bind quad_channel_level_histogram qclh_checker u_qclh_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .channel_index    (out_ch.channel_index),
  .count_code_zero  (out_ch.count_code_zero),
  .count_code_one   (out_ch.count_code_one),
  .count_code_two   (out_ch.count_code_two),
  .count_code_three (out_ch.count_code_three),
  .window_total     (out_ch.window_total),
  .last_channel     (out_ch.last_channel)
);
